// ===== sv/lps_pkg.sv =====
`timescale 1ns / 1ps
// lps_pkg: shared types, opcodes and the Wang 64-bit mix step for the
// linear-probing hash set. No dependencies.
package lps_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 11;

  // One classified item as it waits between front and back.
  typedef struct packed {
    logic             op;
    logic             zero;   // key + 1 wrapped to the empty mark
    logic [KEY_W-1:0] elem;   // key + 1
  } qitem_t;

  localparam int QITEM_W = $bits(qitem_t);

  typedef struct packed {
    logic               found;
    logic               inserted;
    logic               table_full;
    logic               over_half;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // One of the four rounds of the Wang mix; each is a shift-and-add, and all but the last end in an xor-shift.
  function automatic logic [KEY_W-1:0] wang_step(input logic [1:0] step,
                                                  input logic [KEY_W-1:0] v);
    logic [KEY_W-1:0] t;
    case (step)
      2'd0: begin
        t = (~v) + (v << 21);
        t = t ^ (t >> 24);
      end
      2'd1: begin
        t = v + (v << 3) + (v << 8);
        t = t ^ (t >> 14);
      end
      2'd2: begin
        t = v + (v << 2) + (v << 4);
        t = t ^ (t >> 28);
      end
      default: begin
        t = v + (v << 31);
      end
    endcase
    return t;
  endfunction

endpackage

// ===== sv/linear_probe_hash_set.sv =====
`timescale 1ns / 1ps
// linear_probe_hash_set: open-addressing set of 64-bit keys, linear probing.
// Front: takes a new item only when idle or while it pushes the last one, after
//   the hash rounds (and the folded remainder if SLOTS is not a power of two).
// Back: probes on from the home slot to a hit, an empty slot or a full pass.
// Reset: a clearing pass writes every slot, in_stall high meanwhile.
module linear_probe_hash_set #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [63:0] key,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic        inserted,
  output logic        table_full,
  output logic        over_half,
  output logic [10:0] entry_count
);
  import lps_pkg::*;

  // Slot index width; SLOTS need not be a power of two.
  localparam int SW = $clog2(SLOTS);
  localparam int QW = QITEM_W + SW;

  logic             clearing;
  logic             f_push, q_ready, q_valid, q_pop;
  qitem_t           f_item, b_item;
  logic [SW-1:0]    f_home, b_home;
  logic [QW-1:0]    q_rdata;
  result_t          res;

  // Front: takes a transfer, hashes key + 1 to a home slot.
  lps_front #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .key      (key),
    .q_push   (f_push),
    .q_ready  (q_ready),
    .q_item   (f_item),
    .q_home   (f_home)
  );

  // Short queue decouples the hash rounds from the probe loop.
  lps_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_item, f_home}),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign b_item = q_rdata[QW-1:SW];
  assign b_home = q_rdata[SW-1:0];

  // Back: one probe per cycle through the registered slot memory read.
  lps_back #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (b_item),
    .q_home    (b_home),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign found       = res.found;
  assign inserted    = res.inserted;
  assign table_full  = res.table_full;
  assign over_half   = res.over_half;
  assign entry_count = res.entry_count;

endmodule

// ===== sv/lps_front.sv =====
`timescale 1ns / 1ps
// lps_front: accepts items, forms key + 1, runs the Wang mix over shared
// rounds and reduces it to a home slot. Depends on lps_pkg.
module lps_front #(
  parameter int SLOTS = 1024,
  parameter int SW    = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        hold,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [lps_pkg::KEY_W-1:0]   key,
  output logic                        q_push,
  input  logic                        q_ready,
  output lps_pkg::qitem_t             q_item,
  output logic [SW-1:0]               q_home
);
  import lps_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  localparam bit          POW2     = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [SW:0] MODV     = (SW + 1)'(SLOTS);
  localparam logic [1:0]  LAST_REG = POW2 ? 2'd2 : 2'd3;
  // 2^32 mod SLOTS folds the high word down; RECIP is 2^RSH / SLOTS.
  localparam int          RSH      = 31 + SW;
  localparam logic [31:0] FOLD_K   = 32'((64'd1 << 32) % 64'(SLOTS));
  localparam logic [31:0] RECIP    = 32'((64'd1 << RSH) / 64'(SLOTS));
  localparam logic [31:0] SLOTS32  = 32'(SLOTS);

  fstate_t          state, state_next;
  qitem_t           item;
  logic [KEY_W-1:0] v;
  logic [1:0]       step;
  logic [2:0]       mcnt;
  logic [31:0]      quo;
  logic [SW:0]      rem;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic [SW-1:0]    home_mod;
  logic [KEY_W-1:0] hfin;
  logic             accept;

  // One shared multiplier: steps 0-3 fold the high word, step 4 takes the
  // reciprocal product, step 5 multiplies the quotient back by SLOTS.
  always_comb begin
    case (mcnt)
      3'd4: begin
        mul_a = v[31:0];
        mul_b = RECIP;
      end
      3'd5: begin
        mul_a = quo;
        mul_b = SLOTS32;
      end
      default: begin
        mul_a = v[63:32];
        mul_b = FOLD_K;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Quotient estimate is at most one short, so one subtract finishes it.
  assign home_mod = (rem >= MODV) ? SW'(rem - MODV) : rem[SW-1:0];

  assign hfin     = wang_step(2'd3, v);
  assign q_item   = item;
  assign q_home   = POW2 ? hfin[SW-1:0] : home_mod;
  assign q_push   = (state == F_PUSH) && q_ready;
  assign in_stall = hold || !((state == F_IDLE) || ((state == F_PUSH) && q_ready));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_HASH;
      F_HASH: begin
        if (step == LAST_REG) state_next = POW2 ? F_PUSH : F_MOD;
      end
      F_MOD:  if (mcnt == 3'd5) state_next = F_PUSH;
      F_PUSH: begin
        if (q_ready) state_next = accept ? F_HASH : F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op   <= op;
      item.zero <= &key;
      item.elem <= key + 64'd1;
      v         <= key + 64'd1;
      step      <= 2'd0;
    end else if (state == F_HASH) begin
      v    <= wang_step(step, v);
      step <= step + 2'd1;
      rem  <= '0;
      mcnt <= 3'd0;
    end else if (state == F_MOD) begin
      case (mcnt)
        3'd4:    quo <= 32'(prod >> RSH);
        3'd5:    rem <= (SW + 1)'(v[31:0] - prod[31:0]);
        default: v   <= prod + {32'd0, v[31:0]};
      endcase
      mcnt <= mcnt + 3'd1;
    end
  end

endmodule

// ===== sv/lps_queue.sv =====
`timescale 1ns / 1ps
// lps_queue: two-entry FIFO between the front and the back.
// No dependencies.
module lps_queue #(
  parameter int W = 76
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         ready,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem [2];
  logic         wptr, rptr;
  logic [1:0]   cnt;

  assign ready = cnt != 2'd2;
  assign valid = cnt != 2'd0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ===== sv/lps_back.sv =====
`timescale 1ns / 1ps
// lps_back: slot memory, clearing pass, linear probe sequencer, entry
// counter and result register. Depends on lps_pkg.
module lps_back #(
  parameter int SLOTS = 1024,
  parameter int SW    = 10
) (
  input  logic             clk,
  input  logic             rst,
  output logic             clearing,
  input  logic             q_valid,
  output logic             q_pop,
  input  lps_pkg::qitem_t  q_item,
  input  logic [SW-1:0]    q_home,
  output logic             out_valid,
  input  logic             out_stall,
  output lps_pkg::result_t res
);
  import lps_pkg::*;

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_PROBE = 3'b100
  } bstate_t;

  localparam int            CW   = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] HALF = CW'(SLOTS / 2);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  logic [KEY_W-1:0] mem [SLOTS];
  logic [KEY_W-1:0] rd_data;
  logic [SW-1:0]    rd_idx;
  logic             mem_we;
  logic [SW-1:0]    mem_wa;
  logic [KEY_W-1:0] mem_wd;

  bstate_t          state, state_next;
  qitem_t           cur;
  logic [SW-1:0]    chk_pos, nxt_pos;
  logic [SW-1:0]    probes;
  logic [SW-1:0]    clr_idx;
  logic [CW-1:0]    count;
  logic             hit, empty, finish, out_free, do_insert, done;

  assign clearing  = state == B_CLEAR;
  assign hit       = !cur.zero && (rd_data == cur.elem);
  assign empty     = !cur.zero && (rd_data == '0);
  assign finish    = cur.zero || hit || empty || (probes == LAST);
  assign out_free  = !out_valid || !out_stall;
  assign done      = (state == B_PROBE) && finish && out_free;
  assign do_insert = done && empty && (cur.op == OP_INSERT);
  assign nxt_pos   = (chk_pos == LAST) ? '0 : chk_pos + SW'(1);
  assign q_pop     = (state == B_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    rd_idx     = chk_pos;
    mem_we     = 1'b0;
    mem_wa     = chk_pos;
    mem_wd     = cur.elem;
    case (state)
      B_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = '0;
        if (clr_idx == LAST) state_next = B_IDLE;
      end
      B_IDLE: begin
        rd_idx = q_home;
        if (q_valid) state_next = B_PROBE;
      end
      B_PROBE: begin
        if (!finish) begin
          rd_idx = nxt_pos;
        end else if (out_free) begin
          mem_we     = do_insert;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) clr_idx <= clr_idx + SW'(1);
      if (do_insert) count <= count + CW'(1);
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_item;
      chk_pos <= q_home;
      probes  <= '0;
    end else if ((state == B_PROBE) && !finish) begin
      chk_pos <= nxt_pos;
      probes  <= probes + SW'(1);
    end
    if (done) begin
      res.found       <= hit;
      res.inserted    <= do_insert;
      res.table_full  <= !cur.zero && !hit && !empty;
      res.over_half   <= count >= HALF;
      res.entry_count <= COUNT_W'(count + CW'(do_insert));
    end
  end

endmodule

// ===== sv/lps_checker.sv =====
`timescale 1ns / 1ps
// lps_checker: port-level assertions for linear_probe_hash_set, bound to
// the top level below. No package dependency.
module lps_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        found,
  input logic        inserted,
  input logic        table_full,
  input logic        over_half,
  input logic [10:0] entry_count
);

  logic [10:0] prev_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cnt <= 11'd0;
    end else if (out_valid && !out_stall) begin
      prev_cnt <= entry_count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({found, inserted, table_full}) <= 1)
    else $error("found, inserted and table_full not exclusive");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count == prev_cnt + {10'd0, inserted})
    else $error("entry_count does not follow inserts");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> over_half)
    else $error("table_full without over_half");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind linear_probe_hash_set lps_checker u_lps_checker (.*);

// ===== tb/linear_probe_hash_set_checker.sv =====
`timescale 1ns / 1ps
// linear_probe_hash_set_checker: watches both channels of the hash set and keeps a
// shadow copy of the slot store and entry count, so it can check every result transfer.
// Depends on lps_pkg for result_t, the opcodes and the field widths.
module linear_probe_hash_set_checker #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        op,
  input  logic [63:0] key,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        found,
  input  logic        inserted,
  input  logic        table_full,
  input  logic        over_half,
  input  logic [10:0] entry_count,
  output int          fail_count,
  output int          pending
);
  import lps_pkg::*;

  logic [KEY_W-1:0] shadow_slots [SLOTS];
  int unsigned      shadow_count;
  result_t          awaited_results [$];

  // 64-bit Wang integer mix
  function automatic logic [KEY_W-1:0] wang64(input logic [KEY_W-1:0] x);
    logic [KEY_W-1:0] v;
    v = (~x) + (x << 21);
    v = v ^ (v >> 24);
    v = v + (v << 3) + (v << 8);
    v = v ^ (v >> 14);
    v = v + (v << 2) + (v << 4);
    v = v ^ (v >> 28);
    v = v + (v << 31);
    return v;
  endfunction

  // Runs one item against the shadow store and returns the result it must produce.
  function automatic result_t set_apply(input logic item_op, input logic [KEY_W-1:0] item_key);
    result_t          r;
    logic [KEY_W-1:0] elem;
    logic [KEY_W-1:0] slot_word;
    int unsigned      slot;
    int               n;
    bit               done;
    r = '0;
    r.over_half = (shadow_count >= SLOTS / 2);
    elem = item_key + 64'd1;
    done = 1'b0;
    if (elem != '0) begin
      slot = int'(wang64(elem) % 64'(SLOTS));
      for (n = 0; n < SLOTS && !done; n++) begin
        slot_word = shadow_slots[slot];
        if (slot_word == elem) begin
          r.found = 1'b1;
          done = 1'b1;
        end else if (slot_word == '0) begin
          if (item_op == OP_INSERT) begin
            shadow_slots[slot] = elem;
            shadow_count++;
            r.inserted = 1'b1;
          end
          done = 1'b1;
        end else begin
          slot = (slot + 1) % SLOTS;
        end
      end
      r.table_full = !done;
    end
    r.entry_count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [10:0] want_v,
                               input logic [10:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    int      i;
    if (rst) begin
      for (i = 0; i < SLOTS; i++) shadow_slots[i] = '0;
      shadow_count = 0;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      // results first: a transfer in this cycle cannot belong to an item taken in it
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no item awaiting one");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("found", 11'(want.found), 11'(found));
          compare_field("inserted", 11'(want.inserted), 11'(inserted));
          compare_field("table_full", 11'(want.table_full), 11'(table_full));
          compare_field("over_half", 11'(want.over_half), 11'(over_half));
          compare_field("entry_count", want.entry_count, entry_count);
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(set_apply(op, key));
    end
    pending <= awaited_results.size();
  end

endmodule

// ===== tb/linear_probe_hash_set_tb.sv =====
`timescale 1ns / 1ps
// linear_probe_hash_set_tb: stimulus and verdict for the linear-probing hash set.
// Depends on lps_pkg, linear_probe_hash_set and linear_probe_hash_set_checker.
module linear_probe_hash_set_tb;
  import lps_pkg::*;

  localparam int SLOTS        = 1024;
  localparam int MIXED_ITEMS  = 150;
  localparam int FILL_TARGET  = 540;
  localparam int TAIL_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 600;
  // a stray result could still need a full probe of the table
  localparam int DRAIN_CYCLES = SLOTS + 64;
  // watchdog limit, well above the slowest legal run
  localparam int LIMIT        = 6_000_000;

  // extremes and alternating bit patterns; all-ones is handled on its own
  localparam logic [63:0] CORNER_KEYS [7] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_0000_0001,
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_INSERT;
  logic [63:0] key = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic        inserted;
  logic        table_full;
  logic        over_half;
  logic [10:0] entry_count;

  int fail_count;
  int pending;
  int cycle_count;

  // stimulus shaping
  logic        quiet = 1'b0;     // final stretch: no idling on either side
  logic        hold_req = 1'b0;  // asks the receiver for its long hold-off
  bit          calm;             // sender runs this stretch without gaps
  int unsigned fresh_inserts;    // distinct new keys sent as inserts
  logic [63:0] sent_keys [$];    // keys sent for insertion, source for hits

  linear_probe_hash_set #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .inserted(inserted), .table_full(table_full),
    .over_half(over_half), .entry_count(entry_count)
  );

  linear_probe_hash_set_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .inserted(inserted), .table_full(table_full),
    .over_half(over_half), .entry_count(entry_count),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random 64-bit key, never all-ones (that one only comes in on purpose).
  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    if (&k) k = k - 64'd1;
    return k;
  endfunction

  function automatic logic [63:0] any_sent_key();
    return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
  endfunction

  // Offers one item and returns at the edge of its transfer. An optional idle gap
  // may come first; back-to-back items keep valid high, so each signal sees a
  // single nonblocking update per edge.
  task automatic offer(input logic op_v, input logic [63:0] key_v);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_v;
    key      <= key_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic insert_fresh();
    logic [63:0] k;
    k = fresh_key();
    sent_keys.push_back(k);
    fresh_inserts++;
    offer(OP_INSERT, k);
  endtask

  // Receiver side: bursts of stall and run, one long hold-off on request so the
  // block backs up into its input, and no stall at all once quiet.
  initial begin
    int  held;
    bit  hold_done;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        // long runs give stretches with no receiver idling
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
  end

  // Sender side and verdict.
  initial begin
    int unsigned r;
    int          n;
    calm = 1'b0;
    fresh_inserts = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: lookup on an empty table, inserts of the extreme keys, a repeat
    // insert, hits on all of them, the all-ones key that maps onto the empty
    // mark, and a miss once the table holds something.
    offer(OP_LOOKUP, CORNER_KEYS[0]);
    foreach (CORNER_KEYS[i]) begin
      offer(OP_INSERT, CORNER_KEYS[i]);
      sent_keys.push_back(CORNER_KEYS[i]);
    end
    offer(OP_INSERT, CORNER_KEYS[0]);
    foreach (CORNER_KEYS[i]) offer(OP_LOOKUP, CORNER_KEYS[i]);
    offer(OP_INSERT, '1);
    offer(OP_LOOKUP, '1);
    offer(OP_LOOKUP, 64'h0123_4567_89AB_CDEF);

    // Mixed traffic, mostly new inserts so the load climbs; hits, repeat
    // inserts, misses, the all-ones key and small noise keys fill the rest.
    for (n = 0; n < MIXED_ITEMS; n++) begin
      if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 120) hold_req <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 60) insert_fresh();
      else if (r < 74) offer(OP_LOOKUP, any_sent_key());
      else if (r < 82) offer(OP_INSERT, any_sent_key());
      else if (r < 92) offer(OP_LOOKUP, fresh_key());
      else if (r < 95) offer(1'($urandom_range(0, 1)), '1);
      else offer(1'($urandom_range(0, 1)), 64'($urandom_range(0, 15)));
    end

    // Fill: new inserts with a few hits until the load is past half, so
    // over_half turns on and probe chains get longer.
    n = 0;
    while (fresh_inserts < FILL_TARGET) begin
      if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) offer(OP_LOOKUP, any_sent_key());
      else insert_fresh();
      n++;
    end

    // Past half load, no idling from here on: new inserts, misses, hits on
    // stored keys, repeat inserts and the all-ones key.
    quiet <= 1'b1;
    for (n = 0; n < TAIL_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 20) insert_fresh();
      else if (r < 40) offer(OP_LOOKUP, fresh_key());
      else if (r < 65) offer(OP_LOOKUP, any_sent_key());
      else if (r < 85) offer(OP_INSERT, any_sent_key());
      else offer(1'($urandom_range(0, 1)), '1);
    end
    in_valid <= 1'b0;

    // let the last transfer reach the checker, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: covers a hung handshake or a result that never comes.
  initial begin
    for (cycle_count = 0; cycle_count < LIMIT; cycle_count++) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

endmodule
